>>> design/byte_pattern_search_macros.svh
// Assertion macros used by the byte pattern search RTL.
`ifndef BYTE_PATTERN_SEARCH_MACROS_SVH
`define BYTE_PATTERN_SEARCH_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clk, disabled while arst_n is low.
`define BPS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, sampled on clk, disabled while arst_n is low.
`define BPS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BPS_ASSERT_IMP(lbl, ante, cons, msg)
`define BPS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

>>> design/bps_pkg.sv
// Types and register codes for the byte pattern search block.
`timescale 1ns / 1ps
`default_nettype none

package bps_pkg;

	// Configuration register indexes.
	localparam logic [1:0] REG_PATTERN_LENGTH = 2'd0;
	localparam logic [1:0] REG_START_INDEX    = 2'd1;

	// Input item kinds.
	localparam logic KIND_PATTERN = 1'b0;
	localparam logic KIND_PAGE    = 1'b1;

	// One search result.
	typedef struct packed {
		logic        found;
		logic [23:0] match_index;
	} result_t;

endpackage

`default_nettype wire

>>> design/byte_pattern_search.sv
// Top level of the byte pattern search block: pattern store, byte window and result queue.
`timescale 1ns / 1ps
`default_nettype none
`include "byte_pattern_search_macros.svh"

// Channel   Direction  tdata              tuser      tlast
// s_*       in         value[7:0]         kind       last page byte
// m_*       out        match_index[23:0]  found      (none)
// cfg_*     in         write data         (none)     (none)
//
// Each request is handled combinationally: the window shift, the parallel compare against the
// stored pattern and the offset checks all sit between the state registers and the
// result queue, so a new request can be accepted on every clock while s_tready is high.
// Results go into a two-entry queue (an output register plus a skid slot); s_tready
// drops only while both entries are full, that is, while m_tready has been low long
// enough to back up two results.
// arst_n clears the pattern store, the window, all counters, the registers to their
// reset values (pattern_length = 1, start_index = 0) and the queue.
module byte_pattern_search
	import bps_pkg::*;
#(
	parameter int           PATTERN_MAX    = 16,
	parameter longint unsigned PAGE_BYTES_MAX = 64'd16777216
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration write port.
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [23:0] cfg_wdata,
	// Request stream.
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] value
	input  wire logic        s_tuser,   // [0] kind
	input  wire logic        s_tlast,
	// Result stream.
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [23:0] m_tdata,   // [23:0] match_index
	output      logic        m_tuser    // [0] found
);

	localparam int LEN_W = $clog2(PATTERN_MAX + 1);
	localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int CNT_W = $clog2(PAGE_BYTES_MAX + 1);
	// Offset arithmetic width: covers the counter and the 24-bit start_index, plus one.
	localparam int OFS_W = ((CNT_W > 24) ? CNT_W : 24) + 1;

	// Architectural state.
	logic [7:0]       pattern_q [PATTERN_MAX];
	logic [7:0]       window_q  [PATTERN_MAX];
	logic [LEN_W-1:0] fill_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             reported_q;
	logic [4:0]       pattern_length_q;
	logic [23:0]      start_index_q;

	// Result queue: head drives the master side, skid catches one more result.
	result_t head_q, skid_q;
	logic    head_valid_q, skid_valid_q;

	logic accept, page_acc, pat_acc;
	logic [7:0]       win_next [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] hit_by_len;
	logic [LEN_W-1:0] len;
	logic [LEN_W-1:0] len_m1;
	logic [OFS_W-1:0] offset_w, end_w, len_w, start_w;
	logic             window_hit, hit, push, pop;
	result_t          new_res;

	assign s_tready = !skid_valid_q;
	assign accept   = s_tvalid && s_tready;
	assign page_acc = accept && (s_tuser == KIND_PAGE);
	assign pat_acc  = accept && (s_tuser == KIND_PATTERN);

	// Clamp the programmed length into 1..PATTERN_MAX.
	always_comb begin
		if (pattern_length_q == 5'd0) begin
			len = LEN_W'(1);
		end else if (32'(pattern_length_q) > PATTERN_MAX) begin
			len = LEN_W'(PATTERN_MAX);
		end else begin
			len = LEN_W'(pattern_length_q);
		end
		len_m1 = len - LEN_W'(1);
	end

	// Window as it stands once the new page byte is shifted in.
	always_comb begin
		win_next[0] = s_tdata;
		for (int k = 1; k < PATTERN_MAX; k++) begin
			win_next[k] = window_q[k-1];
		end
	end

	// One match flag per candidate length, all built from fixed taps; the clamped
	// length then picks one. The oldest window byte in use lines up with pattern byte 0.
	always_comb begin
		for (int l = 1; l <= PATTERN_MAX; l++) begin
			hit_by_len[l-1] = 1'b1;
			for (int k = 0; k < l; k++) begin
				hit_by_len[l-1] = hit_by_len[l-1] && (pattern_q[k] == win_next[l-1-k]);
			end
		end
		window_hit = hit_by_len[len_m1[IDX_W-1:0]];
	end

	// Offset checks: the match ends on this byte, so it starts len-1 bytes earlier.
	always_comb begin
		offset_w = OFS_W'(count_q);
		end_w    = offset_w + OFS_W'(1);
		len_w    = OFS_W'(len);
		start_w  = end_w - len_w;
		hit = page_acc && !reported_q && (64'(count_q) < PAGE_BYTES_MAX)
			&& (end_w >= len_w) && (start_w >= OFS_W'(start_index_q)) && window_hit;
		new_res.found       = hit;
		new_res.match_index = hit ? start_w[23:0] : 24'd0;
		// A page that ends without a match still reports once, with found clear.
		push = hit || (page_acc && s_tlast && !reported_q);
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q <= 5'd1;
			start_index_q    <= 24'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PATTERN_LENGTH: pattern_length_q <= cfg_wdata[4:0];
				REG_START_INDEX:    start_index_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Pattern store and fill pointer. Loads past the last slot are dropped; the
	// last page byte rewinds the pointer but keeps the stored bytes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PATTERN_MAX; k++) begin
				pattern_q[k] <= 8'd0;
			end
			fill_ptr_q <= '0;
		end else if (pat_acc) begin
			for (int k = 0; k < PATTERN_MAX; k++) begin
				if (fill_ptr_q == LEN_W'(k)) begin
					pattern_q[k] <= s_tdata;
				end
			end
			if (32'(fill_ptr_q) < PATTERN_MAX) begin
				fill_ptr_q <= fill_ptr_q + LEN_W'(1);
			end
		end else if (page_acc && s_tlast) begin
			fill_ptr_q <= '0;
		end
	end

	// Byte window, page byte counter and the reported flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PATTERN_MAX; k++) begin
				window_q[k] <= 8'd0;
			end
			count_q    <= '0;
			reported_q <= 1'b0;
		end else if (page_acc) begin
			if (s_tlast) begin
				for (int k = 0; k < PATTERN_MAX; k++) begin
					window_q[k] <= 8'd0;
				end
				count_q    <= '0;
				reported_q <= 1'b0;
			end else begin
				for (int k = 0; k < PATTERN_MAX; k++) begin
					window_q[k] <= win_next[k];
				end
				if (64'(count_q) < PAGE_BYTES_MAX) begin
					count_q <= count_q + CNT_W'(1);
				end
				if (hit) begin
					reported_q <= 1'b1;
				end
			end
		end
	end

	// Two-entry result queue.
	assign pop = head_valid_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= push;
			end else begin
				head_valid_q <= push;
			end
		end else if (push) begin
			if (head_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				head_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				head_q <= skid_q;
				skid_q <= new_res;
			end else begin
				head_q <= new_res;
			end
		end else if (push) begin
			if (head_valid_q) begin
				skid_q <= new_res;
			end else begin
				head_q <= new_res;
			end
		end
	end

	assign m_tvalid = head_valid_q;
	assign m_tdata  = head_q.match_index;
	assign m_tuser  = head_q.found;

	`BPS_ASSERT_IMP(a_skid_needs_head, skid_valid_q, head_valid_q, "skid entry without head entry")
	`BPS_ASSERT_IMP(a_one_match, push && new_res.found, !reported_q, "second match in one page")
	`BPS_ASSERT_NXT(a_rearm, page_acc && s_tlast, (count_q == '0) && !reported_q && (fill_ptr_q == '0), "last byte did not rearm")
	`BPS_ASSERT_IMP(a_fill_bound, 1'b1, 32'(fill_ptr_q) <= PATTERN_MAX, "fill pointer past the store")

endmodule

`default_nettype wire
